// ----- rtl/morph_pkg.sv -----
package morph_pkg;

	localparam int MAX_WIDTH_DEF     = 1024;
	localparam int PIXEL_BITS_DEF    = 8;

	localparam int IMAGE_WIDTH_BITS  = 11;
	localparam int IMAGE_HEIGHT_BITS = 13;
	localparam int CFG_DATA_BITS     = 13;
	localparam int CFG_INDEX_BITS    = 2;

	localparam logic [IMAGE_WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [IMAGE_HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [IMAGE_HEIGHT_BITS-1:0] HEIGHT_LIMIT = 13'd8190;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_IMAGE_WIDTH    = 2'd0,
		REG_IMAGE_HEIGHT   = 2'd1,
		REG_OPERATION_MODE = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		MODE_DILATE = 1'b0,
		MODE_ERODE  = 1'b1
	} op_mode_t;

	typedef struct packed {
		logic use_up;
		logic use_mid;
		logic col_first;
		logic emit;
		logic last;
	} item_ctl_t;

endpackage

// ----- rtl/morph_ram.sv -----
module morph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/morph_seq.sv -----
module morph_seq import morph_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      accept,
	input  logic [PIXEL_BITS-1:0]     pixel_value,
	input  logic                      pad_item,
	output logic [AW-1:0]             rd_addr,
	output logic [PIXEL_BITS-1:0]     cur_pixel,
	output item_ctl_t                 ctl,
	output op_mode_t                  mode,
	output logic                      restart
);

	localparam int WCW = (IMAGE_WIDTH_BITS > AW + 1) ? IMAGE_WIDTH_BITS : AW + 1;
	localparam int HW  = IMAGE_HEIGHT_BITS;

	logic [IMAGE_WIDTH_BITS-1:0] width_q;
	logic [HW-1:0]               height_q;
	op_mode_t                    mode_q;
	logic [AW-1:0]               col_q;
	logic [HW-1:0]               row_q;

	logic [WCW-1:0] w_eff;
	logic [WCW-1:0] col_inc;
	logic [HW-1:0]  h_eff;
	logic [HW:0]    h_p1;
	logic [HW:0]    row_ext;
	logic           col_first;
	logic           wrap;

	always_comb begin
		restart = 1'b0;
		if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:    restart = 1'b1;
				REG_IMAGE_HEIGHT:   restart = 1'b1;
				REG_OPERATION_MODE: restart = 1'b1;
				default:            restart = 1'b0;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			w_eff = WCW'(1);
		end else if (WCW'(width_q) > WCW'(MAX_WIDTH)) begin
			w_eff = WCW'(MAX_WIDTH);
		end else begin
			w_eff = WCW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (height_q > HEIGHT_LIMIT) begin
			h_eff = HEIGHT_LIMIT;
		end else begin
			h_eff = height_q;
		end
	end

	assign h_p1      = {1'b0, h_eff} + (HW+1)'(1);
	assign row_ext   = {1'b0, row_q};
	assign col_first = (col_q == '0);
	assign wrap      = col_first && (row_ext >= h_p1);
	assign col_inc   = WCW'(col_q) + WCW'(1);

	assign rd_addr       = col_q;
	assign cur_pixel     = (pad_item || row_q >= h_eff) ? '0 : pixel_value;
	assign ctl.use_up    = (row_q >= HW'(2));
	assign ctl.use_mid   = (row_q != '0);
	assign ctl.col_first = col_first;
	assign ctl.emit      = col_first ? (row_q >= HW'(2) && row_ext <= h_p1)
	                                 : (row_q != '0 && row_q <= h_eff);
	assign ctl.last      = col_first && (row_ext == h_p1);
	assign mode          = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			mode_q   <= MODE_DILATE;
			col_q    <= '0;
			row_q    <= '0;
		end else if (restart) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:    width_q  <= cfg_data[IMAGE_WIDTH_BITS-1:0];
				REG_IMAGE_HEIGHT:   height_q <= cfg_data[HW-1:0];
				REG_OPERATION_MODE: mode_q   <= op_mode_t'(cfg_data[0]);
				default:            mode_q   <= mode_q;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (wrap) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= w_eff) begin
				col_q <= '0;
				row_q <= row_q + HW'(1);
			end else begin
				col_q <= col_inc[AW-1:0];
			end
		end
	end

endmodule

// ----- rtl/morph_win.sv -----
module morph_win import morph_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  accept,
	input  logic [AW-1:0]         rd_addr,
	input  logic [PIXEL_BITS-1:0] cur_pixel,
	input  item_ctl_t             ctl,
	input  op_mode_t              mode,
	input  logic                  restart,
	input  logic [PIXEL_BITS-1:0] upper_rdata,
	input  logic [PIXEL_BITS-1:0] middle_rdata,
	output logic                  wr_en,
	output logic [AW-1:0]         wr_addr,
	output logic [PIXEL_BITS-1:0] upper_wdata,
	output logic [PIXEL_BITS-1:0] middle_wdata,
	output logic                  out_valid,
	output logic [PIXEL_BITS-1:0] filtered_value,
	output logic                  frame_end
);

	logic                  valid_s1;
	logic [AW-1:0]         addr_s1;
	logic [PIXEL_BITS-1:0] cur_s1;
	item_ctl_t             ctl_s1;
	logic                  fwd_s1;
	logic [PIXEL_BITS-1:0] fwd_up_s1;
	logic [PIXEL_BITS-1:0] fwd_mid_s1;
	logic [PIXEL_BITS-1:0] left_q;
	logic [PIXEL_BITS-1:0] centre_q;
	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] out_value_q;
	logic                  out_last_q;

	logic                  retire;
	logic                  fwd_hit;
	logic [PIXEL_BITS-1:0] up;
	logic [PIXEL_BITS-1:0] mid;
	logic [PIXEL_BITS-1:0] col;
	logic [PIXEL_BITS-1:0] right;
	logic [PIXEL_BITS-1:0] res;

	function automatic logic [PIXEL_BITS-1:0] pick(
		input op_mode_t m,
		input logic [PIXEL_BITS-1:0] a,
		input logic [PIXEL_BITS-1:0] b
	);
		if (m == MODE_ERODE) begin
			return (a < b) ? a : b;
		end
		return (a > b) ? a : b;
	endfunction

	assign retire  = en && valid_s1;
	assign fwd_hit = retire && (addr_s1 == rd_addr);

	// same-entry overlap: the previous item writes back as this one reads
	always_comb begin
		up    = ctl_s1.use_up  ? (fwd_s1 ? fwd_up_s1  : upper_rdata)  : '0;
		mid   = ctl_s1.use_mid ? (fwd_s1 ? fwd_mid_s1 : middle_rdata) : '0;
		col   = pick(mode, pick(mode, up, mid), cur_s1);
		right = ctl_s1.col_first ? '0 : col;
		res   = pick(mode, pick(mode, left_q, centre_q), right);
	end

	assign wr_en        = retire;
	assign wr_addr      = addr_s1;
	assign upper_wdata  = mid;
	assign middle_wdata = cur_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			left_q      <= '0;
			centre_q    <= '0;
		end else begin
			if (en) begin
				valid_s1    <= accept;
				out_valid_q <= valid_s1 && ctl_s1.emit;
			end
			if (accept) begin
				fwd_s1 <= fwd_hit;
			end
			if (restart) begin
				left_q   <= '0;
				centre_q <= '0;
			end else if (retire) begin
				left_q   <= ctl_s1.col_first ? '0 : centre_q;
				centre_q <= col;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1    <= rd_addr;
			cur_s1     <= cur_pixel;
			ctl_s1     <= ctl;
			fwd_up_s1  <= mid;
			fwd_mid_s1 <= cur_s1;
		end
		if (retire) begin
			out_value_q <= res;
			out_last_q  <= ctl_s1.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_value = out_value_q;
	assign frame_end      = out_last_q;

endmodule

// ----- rtl/morphology_3x3_dilate_erode.sv -----
// channel   signals                                  direction
// cfg       cfg_write cfg_index cfg_data             in
// in        in_valid in_stall pixel_value pad_item   in (in_stall out)
// out       out_valid out_stall filtered_value       out (out_stall in)
//           frame_end
//
// one transaction per clock unless stalled; a result is registered after stage s1
// the line stores are read at accept and written back as the item leaves stage s1,
// with a bypass when both touch the same column
// reset clears positions, column extremes, valid flags; line stores stay uncleared
// a stalled result holds the whole pipe, so in_stall is high exactly then
module morphology_3x3_dilate_erode import morph_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [PIXEL_BITS-1:0]     pixel_value,
	input  logic                      pad_item,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [PIXEL_BITS-1:0]     filtered_value,
	output logic                      frame_end
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic                  en;
	logic                  accept;
	logic [AW-1:0]         rd_addr;
	logic [PIXEL_BITS-1:0] cur_pixel;
	item_ctl_t             ctl;
	op_mode_t              mode;
	logic                  restart;
	logic [PIXEL_BITS-1:0] upper_rdata;
	logic [PIXEL_BITS-1:0] middle_rdata;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [PIXEL_BITS-1:0] upper_wdata;
	logic [PIXEL_BITS-1:0] middle_wdata;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign accept   = in_valid && en;

	morph_seq #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.pixel_value (pixel_value),
		.pad_item    (pad_item),
		.rd_addr     (rd_addr),
		.cur_pixel   (cur_pixel),
		.ctl         (ctl),
		.mode        (mode),
		.restart     (restart)
	);

	morph_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_upper_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (upper_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (upper_rdata)
	);

	morph_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_middle_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (middle_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (middle_rdata)
	);

	morph_win #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_win (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.accept         (accept),
		.rd_addr        (rd_addr),
		.cur_pixel      (cur_pixel),
		.ctl            (ctl),
		.mode           (mode),
		.restart        (restart),
		.upper_rdata    (upper_rdata),
		.middle_rdata   (middle_rdata),
		.wr_en          (wr_en),
		.wr_addr        (wr_addr),
		.upper_wdata    (upper_wdata),
		.middle_wdata   (middle_wdata),
		.out_valid      (out_valid),
		.filtered_value (filtered_value),
		.frame_end      (frame_end)
	);

endmodule

// ----- rtl/morph_chk.sv -----
module morph_chk import morph_pkg::*; #(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [PIXEL_BITS-1:0] filtered_value,
	input logic                  frame_end
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(filtered_value) && $stable(frame_end))
		else $error("stalled result changed");

	// input side only stalls behind a blocked result
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// a fresh result comes from an earlier input transaction
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid && out_stall) && !$past(out_valid && out_stall, 2)
		|-> $past(in_valid && !in_stall, 2))
		else $error("result without an input transaction");

endmodule

bind morphology_3x3_dilate_erode morph_chk #(
	.PIXEL_BITS (PIXEL_BITS)
) u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.filtered_value (filtered_value),
	.frame_end      (frame_end)
);
